### hw/rtl/md5_pkg.sv
// Shared types, constants and round tables of the MD5 message digest block.
// No dependencies; imported by md5_buf, md5_round and md5_message_digest.
package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LAST_POS  = 6'h3f;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_RND  = 6'd63;
  localparam logic [63:0] BYTE_BITS = 64'd8;

  localparam logic [31:0] K_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TAB [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Buffer control from the sequencer
  typedef struct packed {
    logic        clr;
    logic        byte_we;
    logic [5:0]  byte_pos;
    logic [7:0]  byte_val;
    logic        len_we;
    logic [63:0] len;
  } buf_ctl_t;

  // Round unit control from the sequencer
  typedef struct packed {
    logic load;
    logic calc;
    logic step;
  } rnd_ctl_t;

  // Message word used by a round
  function automatic logic [3:0] msg_idx(input logic [5:0] i);
    logic [3:0] l;
    logic [3:0] g;
    l = i[3:0];
    unique case (i[5:4])
      2'd0:    g = l;
      2'd1:    g = 4'((l * 4'd5) + 4'd1);
      2'd2:    g = 4'((l * 4'd3) + 4'd5);
      default: g = 4'(l * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    return ROT_TAB[{i[5:4], i[1:0]}];
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

### hw/rtl/md5_buf.sv
// Block buffer: sixteen little-endian message words with byte and length writes.
// Depends on md5_pkg.
module md5_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  md5_pkg::buf_ctl_t ctl,
  input  logic [3:0]        rd_idx,
  output logic [31:0]       rd_word
);
  import md5_pkg::*;

  logic [31:0] words_r [16];

  // Clear on reset or after a block; otherwise take byte and length writes
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      for (int w = 0; w < 16; w++) words_r[w] <= '0;
    end else begin
      if (ctl.byte_we) begin
        words_r[ctl.byte_pos[5:2]][{ctl.byte_pos[1:0], 3'b000} +: 8] <= ctl.byte_val;
      end
      if (ctl.len_we) begin
        words_r[14] <= ctl.len[31:0];
        words_r[15] <= ctl.len[63:32];
      end
    end
  end

  // Word for the current round
  assign rd_word = words_r[rd_idx];

endmodule

### hw/rtl/md5_round.sv
// Shared MD5 round unit: working words and a round in steps (sum, then rotate and add).
// Depends on md5_pkg.
module md5_round (
  input  logic              clk,
  input  md5_pkg::rnd_ctl_t ctl,
  input  logic [5:0]        rnd_idx,
  input  logic [31:0]       msg_word,
  input  logic [31:0]       init_a,
  input  logic [31:0]       init_b,
  input  logic [31:0]       init_c,
  input  logic [31:0]       init_d,
  output logic [31:0]       a_out,
  output logic [31:0]       b_out,
  output logic [31:0]       c_out,
  output logic [31:0]       d_out
);
  import md5_pkg::*;

  logic [31:0] a_r, b_r, c_r, d_r, sum_r;
  logic [31:0] f_val;
  logic [63:0] rot_wide;
  logic [31:0] rot_val;

  // Round function of the current phase
  always_comb begin
    unique case (rnd_idx[5:4])
      2'd0:    f_val = d_r ^ (b_r & (c_r ^ d_r));
      2'd1:    f_val = c_r ^ (d_r & (b_r ^ c_r));
      2'd2:    f_val = b_r ^ c_r ^ d_r;
      default: f_val = c_r ^ (b_r | ~d_r);
    endcase
  end

  // Rotate the registered sum left
  assign rot_wide = {sum_r, sum_r} << rot_amt(rnd_idx);
  assign rot_val  = rot_wide[63:32];

  // Load, sum, or rotate the words
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r <= init_a;
      b_r <= init_b;
      c_r <= init_c;
      d_r <= init_d;
    end else if (ctl.calc) begin
      sum_r <= a_r + f_val + K_TAB[rnd_idx] + msg_word;
    end else if (ctl.step) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= b_r + rot_val;
    end
  end

  assign a_out = a_r;
  assign b_out = b_r;
  assign c_out = c_r;
  assign d_out = d_r;

endmodule

### hw/rtl/md5_message_digest.sv
// Top level of the MD5 message digest: byte intake, padding sequencer and digest output.
// Depends on md5_pkg, md5_buf and md5_round.
//
//  channel | dir | tdata             | tuser        | tlast
//  in_     | in  | data_byte [7:0]   | byte_present | end_of_message
//  out_    | out | digest_half[63:0] | half_index   | last_half
//
// Byte items are taken back to back while idle; the 64th byte of a block starts the
// compression (load, 64 rounds of sum and rotate steps in the shared unit, chain add).
// Closing a message adds a pad state, a length state and one or two compressions,
// then two output items. in_tready is low throughout. Reset is synchronous and
// restores the MD5 initial chaining words, zero bit count and an empty buffer.
// A stalled output holds its item until out_tready.
module md5_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] digest_half
  output logic        out_tuser,  // [0] half_index
  output logic        out_tlast   // last_half
);
  import md5_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_RA, S_RB, S_FIN, S_PAD, S_LEN, S_OUT0
  } state_t;

  typedef enum logic [1:0] {K_DATA, K_PAD, K_LAST} kind_t;

  state_t      state_r;
  kind_t       kind_r;
  logic        half_r;
  logic        pend_r;
  logic [5:0]  fill_r;
  logic [5:0]  rnd_r;
  logic [63:0] count_r;
  logic [31:0] chain_r [4];

  logic        in_acc;
  logic        out_acc;
  buf_ctl_t    bctl;
  rnd_ctl_t    rctl;
  logic [31:0] msg_word;
  logic [31:0] wa, wb, wc, wd;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  // Buffer writes: message byte, pad byte, length, clears
  always_comb begin
    bctl.byte_we  = (in_acc && in_tuser) || (state_r == S_PAD);
    bctl.byte_pos = fill_r;
    bctl.byte_val = (state_r == S_PAD) ? PAD_BYTE : in_tdata;
    bctl.len_we   = (state_r == S_LEN);
    bctl.len      = count_r;
    bctl.clr      = ((state_r == S_FIN) && (kind_r != K_LAST)) || (out_acc && half_r);
  end

  // Round unit steps
  always_comb begin
    rctl.load = (state_r == S_LOAD);
    rctl.calc = (state_r == S_RA);
    rctl.step = (state_r == S_RB);
  end

  md5_buf u_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (bctl),
    .rd_idx  (msg_idx(rnd_r)),
    .rd_word (msg_word)
  );

  md5_round u_round (
    .clk      (clk),
    .ctl      (rctl),
    .rnd_idx  (rnd_r),
    .msg_word (msg_word),
    .init_a   (chain_r[0]),
    .init_b   (chain_r[1]),
    .init_c   (chain_r[2]),
    .init_d   (chain_r[3]),
    .a_out    (wa),
    .b_out    (wb),
    .c_out    (wc),
    .d_out    (wd)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      kind_r     <= K_DATA;
      half_r     <= 1'b0;
      pend_r     <= 1'b0;
      fill_r     <= '0;
      rnd_r      <= '0;
      count_r    <= '0;
      chain_r[0] <= IV_A;
      chain_r[1] <= IV_B;
      chain_r[2] <= IV_C;
      chain_r[3] <= IV_D;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            pend_r <= in_tlast;
            if (in_tuser) begin
              fill_r  <= fill_r + 6'd1;
              count_r <= count_r + BYTE_BITS;
            end
            // Full block compresses first; a close then pads
            if (in_tuser && (fill_r == LAST_POS)) begin
              kind_r  <= K_DATA;
              state_r <= S_LOAD;
            end else if (in_tlast) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // Length no longer fits: compress this block on its own
          if (fill_r >= LEN_POS) begin
            kind_r  <= K_PAD;
            state_r <= S_LOAD;
          end else begin
            state_r <= S_LEN;
          end
        end
        S_LEN: begin
          kind_r  <= K_LAST;
          state_r <= S_LOAD;
        end
        S_LOAD: state_r <= S_RA;
        S_RA:   state_r <= S_RB;
        S_RB: begin
          rnd_r   <= rnd_r + 6'd1;
          state_r <= (rnd_r == LAST_RND) ? S_FIN : S_RA;
        end
        S_FIN: begin
          chain_r[0] <= chain_r[0] + wa;
          chain_r[1] <= chain_r[1] + wb;
          chain_r[2] <= chain_r[2] + wc;
          chain_r[3] <= chain_r[3] + wd;
          unique case (kind_r)
            K_DATA:  state_r <= pend_r ? S_PAD : S_IDLE;
            K_PAD:   state_r <= S_LEN;
            default: begin
              half_r  <= 1'b0;
              state_r <= S_OUT0;
            end
          endcase
        end
        default: begin
          // Emit both halves, then restart for a new message
          if (out_acc) begin
            if (half_r) begin
              state_r    <= S_IDLE;
              half_r     <= 1'b0;
              pend_r     <= 1'b0;
              fill_r     <= '0;
              count_r    <= '0;
              chain_r[0] <= IV_A;
              chain_r[1] <= IV_B;
              chain_r[2] <= IV_C;
              chain_r[3] <= IV_D;
            end else begin
              half_r <= 1'b1;
            end
          end
        end
      endcase
    end
  end

  // Digest halves in standard byte order
  assign out_tvalid = (state_r == S_OUT0);
  assign out_tuser  = half_r;
  assign out_tlast  = half_r;
  assign out_tdata  = half_r ? {bswap32(chain_r[2]), bswap32(chain_r[3])}
                             : {bswap32(chain_r[0]), bswap32(chain_r[1])};

  // Intake and output never overlap
  assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("input ready while digest output pending");

  // The round counter rests at zero outside a compression
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_OUT0) |-> (rnd_r == '0))
    else $error("round counter not at rest");

  // After the final half the block is back to intake with an empty buffer
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (in_tready && fill_r == '0 && count_r == '0))
    else $error("block did not restart after digest");

  // The second half always follows the first
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_tlast) |=> (out_tvalid && out_tlast))
    else $error("second digest half missing");

endmodule

### dv/tb_md5_message_digest.sv
// Self-checking testbench for the MD5 message digest block: byte stream in, two digest halves out.
// Depends on md5_pkg and md5_message_digest; holds its own bit-exact MD5 predictor.
// A short directed table is followed by random messages with random gaps on both channels.
module tb_md5_message_digest;
  timeunit 1ns;
  timeprecision 1ps;

  import md5_pkg::*;

  localparam int ITEM_TARGET = 2000;
  localparam int DRAIN_CYCLES = 300;
  localparam int IDLE_PCT = 28;
  localparam int DIR_ROWS = 13;

  // One digest half as it leaves the block
  typedef struct packed {
    logic [63:0] half;
    logic        idx;
    logic        last;
  } digest_half_t;

  // One row of directed stimulus; the digest is used only where typed
  typedef struct packed {
    logic [7:0]   data;
    logic         present;
    logic         eom;
    logic         typed;
    logic [127:0] digest;
  } stim_row_t;

  localparam logic [31:0] ROUND_ADD [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int SHIFT_BY [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tuser = 1'b0;    // [0] byte_present
  logic        in_tlast = 1'b0;    // end_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;          // [63:0] digest_half
  logic        out_tuser;          // [0] half_index
  logic        out_tlast;          // last_half

  // Predictor state
  logic [31:0] chain [4];
  logic [63:0] bit_count;
  logic [31:0] block_words [16];
  logic [5:0]  fill;

  digest_half_t expected_halves [$];
  digest_half_t got_half;
  stim_row_t    stim_tab [DIR_ROWS];

  bit calm = 1'b0;
  int fail_count = 0;
  int items_sent = 0;
  int messages_sent = 0;
  int halves_checked = 0;
  int overflow_pads = 0;

  md5_message_digest u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Return the predictor to the state after reset
  function automatic void md5_init();
    chain[0] = IV_A;
    chain[1] = IV_B;
    chain[2] = IV_C;
    chain[3] = IV_D;
    bit_count = '0;
    fill = '0;
    for (int w = 0; w < 16; w++) block_words[w] = '0;
  endfunction

  // Run the 64 rounds over the buffered block and fold into the chain
  function automatic void md5_compress();
    logic [31:0] a, b, c, d, f, sum, rot;
    logic [3:0]  g;
    int          phase, s;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int i = 0; i < 64; i++) begin
      phase = i / 16;
      case (phase)
        0: begin
          f = d ^ (b & (c ^ d));
          g = 4'(i);
        end
        1: begin
          f = c ^ (d & (b ^ c));
          g = 4'(5 * i + 1);
        end
        2: begin
          f = b ^ c ^ d;
          g = 4'(3 * i + 5);
        end
        default: begin
          f = c ^ (b | ~d);
          g = 4'(7 * i);
        end
      endcase
      sum = a + f + ROUND_ADD[i] + block_words[g];
      s = SHIFT_BY[phase * 4 + (i % 4)];
      rot = (sum << s) | (sum >> (32 - s));
      a = d;
      d = c;
      c = b;
      b = b + rot;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
  endfunction

  // Absorb one accepted item; on end of message return 1 with the digest
  function automatic bit md5_absorb(input logic [7:0] data, input logic present,
                                    input logic eom, output logic [127:0] digest);
    digest = '0;
    if (present) begin
      block_words[fill[5:2]][fill[1:0]*8 +: 8] = data;
      bit_count = bit_count + BYTE_BITS;
      fill = fill + 6'd1;
      if (fill == 6'd0) begin
        md5_compress();
        for (int w = 0; w < 16; w++) block_words[w] = '0;
      end
    end
    if (!eom) return 1'b0;
    // Pad with the marker byte and zeros, spilling into an extra block if needed
    block_words[fill[5:2]][fill[1:0]*8 +: 8] = PAD_BYTE;
    for (int p = fill + 1; p < 64; p++) block_words[p / 4][(p % 4)*8 +: 8] = 8'h00;
    if (fill >= LEN_POS) begin
      md5_compress();
      for (int w = 0; w < 16; w++) block_words[w] = '0;
    end
    block_words[14] = bit_count[31:0];
    block_words[15] = bit_count[63:32];
    md5_compress();
    // Emit each chain word little-endian, first word first
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 4; j++)
        digest[127 - 32*k - 8*j -: 8] = chain[k][8*j +: 8];
    md5_init();
    return 1'b1;
  endfunction

  // Offer one item, optionally after random gaps, and hold it until accepted
  task automatic send_item(input logic [7:0] data, input logic present, input logic eom,
                           input logic typed, input logic [127:0] typed_digest);
    logic [127:0] digest;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= present;
    in_tlast  <= eom;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (present || eom) items_sent++;
    if (md5_absorb(data, present, eom, digest)) begin
      if (typed) digest = typed_digest;
      expected_halves.push_back('{digest[127:64], 1'b0, 1'b0});
      expected_halves.push_back('{digest[63:0], 1'b1, 1'b1});
    end
  endtask

  // Send a message of random bytes, with ignored items mixed in and a random close
  task automatic send_message(input int len);
    logic close_on_byte;
    close_on_byte = (len > 0) && ($urandom_range(1) == 1);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(19) == 0) send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
      send_item(8'($urandom), 1'b1, close_on_byte && (k == len - 1), 1'b0, '0);
    end
    if (!close_on_byte) send_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
    if ((len % 64) >= 56) overflow_pads++;
    messages_sent++;
  endtask

  // Hold the sender until every digest half has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_halves.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall at random except in the calm stretch
  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each accepted digest half with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_halves.size() == 0) begin
        $error("digest half with nothing expected: %h", out_tdata);
        fail_count++;
      end else begin
        got_half = expected_halves.pop_front();
        halves_checked++;
        if (out_tdata !== got_half.half) begin
          $error("digest_half: expected %h, actual %h", got_half.half, out_tdata);
          fail_count++;
        end
        if (out_tuser !== got_half.idx) begin
          $error("half_index: expected %0b, actual %0b", got_half.idx, out_tuser);
          fail_count++;
        end
        if (out_tlast !== got_half.last) begin
          $error("last_half: expected %0b, actual %0b", got_half.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int special_len [10];
    int len, pick;
    special_len = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    // Directed rows: empty message, byte with end, ignored items, end without byte
    stim_tab[0]  = '{8'h00, 1'b0, 1'b1, 1'b1, 128'hd41d8cd98f00b204e9800998ecf8427e};
    stim_tab[1]  = '{8'h61, 1'b1, 1'b1, 1'b1, 128'h0cc175b9c0f1b6a831c399e269772661};
    stim_tab[2]  = '{8'ha5, 1'b0, 1'b0, 1'b0, 128'h0};
    stim_tab[3]  = '{8'h61, 1'b1, 1'b0, 1'b0, 128'h0};
    stim_tab[4]  = '{8'h62, 1'b1, 1'b0, 1'b0, 128'h0};
    stim_tab[5]  = '{8'h5a, 1'b0, 1'b0, 1'b0, 128'h0};
    stim_tab[6]  = '{8'h63, 1'b1, 1'b0, 1'b0, 128'h0};
    stim_tab[7]  = '{8'h3c, 1'b0, 1'b1, 1'b1, 128'h900150983cd24fb0d6963f7d28e17f72};
    stim_tab[8]  = '{8'hff, 1'b1, 1'b0, 1'b0, 128'h0};
    stim_tab[9]  = '{8'h00, 1'b1, 1'b0, 1'b0, 128'h0};
    stim_tab[10] = '{8'hff, 1'b1, 1'b1, 1'b0, 128'h0};
    stim_tab[11] = '{8'hff, 1'b0, 1'b1, 1'b1, 128'hd41d8cd98f00b204e9800998ecf8427e};
    stim_tab[12] = '{8'h00, 1'b1, 1'b1, 1'b0, 128'h0};

    md5_init();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int r = 0; r < DIR_ROWS; r++)
      send_item(stim_tab[r].data, stim_tab[r].present, stim_tab[r].eom,
                stim_tab[r].typed, stim_tab[r].digest);
    drain();

    // Lengths around the padding boundary and the block boundary
    for (int s = 0; s < 10; s++) send_message(special_len[s]);

    // Random messages, mostly short, with a calm stretch and periodic drains
    while (items_sent < ITEM_TARGET) begin
      calm = (messages_sent >= 14) && (messages_sent < 22);
      pick = $urandom_range(99);
      if (pick < 80) len = $urandom_range(70);
      else if (pick < 93) len = $urandom_range(200);
      else len = special_len[$urandom_range(9)];
      send_message(len);
      if (messages_sent % 12 == 0) drain();
    end
    calm = 1'b0;
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items in %0d messages, %0d with the pad spilling into an extra block.",
             items_sent, messages_sent, overflow_pads);
    $display("Checked %0d digest halves under random gaps and stalls on both channels.",
             halves_checked);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(4_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
